/* src/lhp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram package
// Request and result types and the constants shared by the histogram block
// and its checker.
// ----------------------------------------------------------------------------
package lhp_pkg;

  localparam int MAX_LATENCY_DEF = 4095;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int LAT_W       = 24;
  localparam int BIN_FIELD_W = 12;

  // The percentile thresholds divide the sample total by 100 and by 1000.
  localparam int REM100_W  = 7;
  localparam int REM1000_W = 10;
  localparam int DIV_P99   = 100;
  localparam int DIV_P999  = 1000;

  typedef enum logic {
    REQ_ADD   = 1'b0,
    REQ_QUERY = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t        req_type;
    logic [LAT_W-1:0] latency_us;
  } in_req_t;

  typedef struct packed {
    logic                   has_samples;
    logic [BIN_FIELD_W-1:0] median_bin;
    logic [BIN_FIELD_W-1:0] p99_bin;
    logic [BIN_FIELD_W-1:0] p999_bin;
  } out_res_t;

endpackage

/* src/latency_histogram_percentiles.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram with nearest-rank percentiles
// An add request increments one saturating bin counter and the sample total.
// Quotients of the total by 100 and by 1000 are kept current on every add,
// so a query derives the 50, 99 and 99.9 percent thresholds at once and then
// scans the bins in ascending order with one shared accumulator.
//
// Usage:
// Requests enter on in_valid/in_stall/in_data and results leave on
// out_valid/out_stall/out_data. A request is taken when valid is high and
// stall is low. Only queries produce a result.
// After reset the bin memory is cleared one bin per cycle, all MAX_LATENCY + 1
// bins (4096 at the defaults), with in_stall held high.
// An add first reads its bin and then writes it back, incremented.
// A query reads one bin per cycle until all three thresholds are reached. A
// query on an empty histogram skips the scan.
// One request is worked on at a time. The result sits in an output register;
// while the receiver stalls it holds, and a following query waits for it to
// be taken before it completes. Adds go on regardless.
// ----------------------------------------------------------------------------
module latency_histogram_percentiles #(
  parameter int MAX_LATENCY = lhp_pkg::MAX_LATENCY_DEF,
  parameter int COUNT_WIDTH = lhp_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lhp_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lhp_pkg::out_res_t out_data
);

  localparam int NUM_BINS = MAX_LATENCY + 1;
  localparam int BIN_W    = $clog2(NUM_BINS);
  localparam int ACC_W    = COUNT_WIDTH + BIN_W;
  localparam int EXT_W    = BIN_W + lhp_pkg::BIN_FIELD_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r;

  logic [COUNT_WIDTH-1:0] mem_r [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic                   mem_we;
  logic [BIN_W-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0] mem_wdata;
  logic [BIN_W-1:0]       mem_raddr;

  logic [BIN_W-1:0]       clr_addr_r;
  logic [BIN_W-1:0]       add_bin_r;
  logic [BIN_W-1:0]       in_bin;
  logic [COUNT_WIDTH-1:0] total_r;
  logic [COUNT_WIDTH-1:0] total_nxt;
  logic                   total_full;
  logic [COUNT_WIDTH-1:0] bin_nxt;

  logic [COUNT_WIDTH-1:0]        q100_r;
  logic [COUNT_WIDTH-1:0]        q1000_r;
  logic [lhp_pkg::REM100_W-1:0]  r100_r;
  logic [lhp_pkg::REM1000_W-1:0] r1000_r;
  logic                          r100_wrap;
  logic                          r1000_wrap;

  logic [COUNT_WIDTH-1:0] t50_r;
  logic [COUNT_WIDTH-1:0] t99_r;
  logic [COUNT_WIDTH-1:0] t999_r;

  logic [BIN_W-1:0] scan_addr_r;
  logic             scan_end_r;
  logic             scan_issue;
  logic             rd_vld_r;
  logic [BIN_W-1:0] rd_bin_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic             f50_r, f99_r, f999_r;
  logic             f50_nxt, f99_nxt, f999_nxt;
  logic [BIN_W-1:0] v50_r, v99_r, v999_r;
  logic             has_r;
  logic             scan_done;

  logic [EXT_W-1:0] ext50, ext99, ext999;

  logic              out_valid_r;
  logic              out_load;
  lhp_pkg::out_res_t out_data_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_bin = (in_data.latency_us > lhp_pkg::LAT_W'(MAX_LATENCY)) ?
                  BIN_W'(MAX_LATENCY) : in_data.latency_us[BIN_W-1:0];

  assign total_full = &total_r;
  assign total_nxt  = total_full ? total_r : total_r + 1'b1;
  assign bin_nxt    = (&rd_data_r) ? rd_data_r : rd_data_r + 1'b1;

  assign r100_wrap  = (r100_r == lhp_pkg::REM100_W'(lhp_pkg::DIV_P99 - 1));
  assign r1000_wrap = (r1000_r == lhp_pkg::REM1000_W'(lhp_pkg::DIV_P999 - 1));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr_r;
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == ST_ADD) begin
      mem_we    = 1'b1;
      mem_waddr = add_bin_r;
      mem_wdata = bin_nxt;
    end
  end

  assign mem_raddr = (state_r == ST_SCAN) ? scan_addr_r : in_bin;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem_r[mem_raddr];
  end

  assign scan_issue = (state_r == ST_SCAN) && !scan_end_r;
  assign acc_nxt    = acc_r + ACC_W'(rd_data_r);
  assign f50_nxt    = f50_r  || (rd_vld_r && (acc_nxt >= ACC_W'(t50_r)));
  assign f99_nxt    = f99_r  || (rd_vld_r && (acc_nxt >= ACC_W'(t99_r)));
  assign f999_nxt   = f999_r || (rd_vld_r && (acc_nxt >= ACC_W'(t999_r)));
  assign scan_done  = rd_vld_r &&
                      ((f50_nxt && f99_nxt && f999_nxt) ||
                       (rd_bin_r == BIN_W'(MAX_LATENCY)));

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  assign ext50  = {{lhp_pkg::BIN_FIELD_W{1'b0}}, v50_r};
  assign ext99  = {{lhp_pkg::BIN_FIELD_W{1'b0}}, v99_r};
  assign ext999 = {{lhp_pkg::BIN_FIELD_W{1'b0}}, v999_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      total_r     <= '0;
      q100_r      <= '0;
      q1000_r     <= '0;
      r100_r      <= '0;
      r1000_r     <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= scan_issue;
      rd_bin_r <= scan_addr_r;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == BIN_W'(MAX_LATENCY)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (in_data.req_type == lhp_pkg::REQ_ADD) begin
              add_bin_r <= in_bin;
              total_r   <= total_nxt;
              if (!total_full) begin
                r100_r  <= r100_wrap ? '0 : r100_r + 1'b1;
                q100_r  <= r100_wrap ? q100_r + 1'b1 : q100_r;
                r1000_r <= r1000_wrap ? '0 : r1000_r + 1'b1;
                q1000_r <= r1000_wrap ? q1000_r + 1'b1 : q1000_r;
              end
              state_r   <= ST_ADD;
            end else begin
              t50_r       <= (total_r >> 1) + COUNT_WIDTH'(total_r[0]);
              t99_r       <= total_r - q100_r;
              t999_r      <= total_r - q1000_r;
              v50_r       <= '0;
              v99_r       <= '0;
              v999_r      <= '0;
              scan_addr_r <= '0;
              scan_end_r  <= 1'b0;
              acc_r       <= '0;
              f50_r       <= 1'b0;
              f99_r       <= 1'b0;
              f999_r      <= 1'b0;
              has_r       <= (total_r != '0);
              state_r     <= (total_r != '0) ? ST_SCAN : ST_DONE;
            end
          end
        end
        ST_ADD: begin
          state_r <= ST_IDLE;
        end
        ST_SCAN: begin
          if (scan_issue) begin
            if (scan_addr_r == BIN_W'(MAX_LATENCY)) begin
              scan_end_r <= 1'b1;
            end else begin
              scan_addr_r <= scan_addr_r + 1'b1;
            end
          end
          if (rd_vld_r) begin
            acc_r  <= acc_nxt;
            f50_r  <= f50_nxt;
            f99_r  <= f99_nxt;
            f999_r <= f999_nxt;
            if (f50_nxt && !f50_r) begin
              v50_r <= rd_bin_r;
            end
            if (f99_nxt && !f99_r) begin
              v99_r <= rd_bin_r;
            end
            if (f999_nxt && !f999_r) begin
              v999_r <= rd_bin_r;
            end
          end
          if (scan_done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_data_r.has_samples <= has_r;
            out_data_r.median_bin  <= ext50[lhp_pkg::BIN_FIELD_W-1:0];
            out_data_r.p99_bin     <= ext99[lhp_pkg::BIN_FIELD_W-1:0];
            out_data_r.p999_bin    <= ext999[lhp_pkg::BIN_FIELD_W-1:0];
            state_r                <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/lhp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram port checker
// Watches the ports of the histogram block for handshake and result rules.
// ----------------------------------------------------------------------------
module lhp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input lhp_pkg::in_req_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input lhp_pkg::out_res_t out_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // An empty histogram reports all percentiles as zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_samples |->
      out_data.median_bin == '0 && out_data.p99_bin == '0 &&
      out_data.p999_bin == '0)
    else $error("empty result carries nonzero bins");

  // The block stalls its input once a request is taken, whether it is an add or a query.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_data.req_type == lhp_pkg::REQ_ADD ||
      in_data.req_type == lhp_pkg::REQ_QUERY) |=> in_stall)
    else $error("request accepted while the previous one is in progress");

  // Reset starts the clearing pass and drops any pending result.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("block not cleared by reset");

endmodule

bind latency_histogram_percentiles lhp_checker u_lhp_checker (.*);

/* tb/tb_latency_histogram_percentiles.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency histogram percentile testbench
// Sends add and query requests and predicts each query's median, p99 and
// p999 bins from a local copy of the bin counters and the sample total.
// Results are checked field by field in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_latency_histogram_percentiles;

  localparam int NUM_BINS       = lhp_pkg::MAX_LATENCY_DEF + 1;
  localparam int CW             = lhp_pkg::COUNT_WIDTH_DEF;
  localparam int RANDOM_ITEMS   = 1530;
  localparam int MIN_QUERIES    = 48;
  localparam int STALL_LIMIT    = 20000;
  localparam int MAX_REPORTS    = 10;
  localparam int CALM_START     = 700;
  localparam int CALM_END       = 1000;
  localparam logic [CW-1:0] COUNT_FULL = '1;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  lhp_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  lhp_pkg::out_res_t out_data;

  lhp_pkg::in_req_t  pending_reqs[$];
  lhp_pkg::out_res_t pct_expected[$];
  logic [CW-1:0]     hist_bins[NUM_BINS];
  logic [CW-1:0]     hist_total;

  logic in_taken = 1'b0;
  int   total_reqs = 0;
  int   reqs_taken = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  latency_histogram_percentiles DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  function automatic logic roll_idle();
    if (reqs_taken >= CALM_START && reqs_taken < CALM_END) begin
      return 1'b0;
    end
    return $urandom_range(0, 99) < 7;
  endfunction

  function automatic logic [CW-1:0] sat_incr(logic [CW-1:0] v);
    return (v == COUNT_FULL) ? v : v + 1'b1;
  endfunction

  function automatic longint unsigned rank_threshold(longint unsigned n, longint unsigned num,
                                                     longint unsigned den);
    return (n * num + den - 1) / den;
  endfunction

  task automatic record_latency(logic [lhp_pkg::LAT_W-1:0] lat);
    int bin;
    bin = (lat > lhp_pkg::MAX_LATENCY_DEF) ? lhp_pkg::MAX_LATENCY_DEF : int'(lat);
    hist_bins[bin] = sat_incr(hist_bins[bin]);
    hist_total = sat_incr(hist_total);
  endtask

  function automatic lhp_pkg::out_res_t percentile_snapshot();
    lhp_pkg::out_res_t res;
    longint unsigned t50, t99, t999, acc;
    logic got50, got99, got999;
    res = '0;
    acc = 0;
    got50 = 1'b0;
    got99 = 1'b0;
    got999 = 1'b0;
    if (hist_total == 0) begin
      return res;
    end
    res.has_samples = 1'b1;
    t50 = rank_threshold(hist_total, 50, 100);
    t99 = rank_threshold(hist_total, 99, 100);
    t999 = rank_threshold(hist_total, 999, 1000);
    for (int i = 0; i < NUM_BINS; i++) begin
      if (hist_bins[i] != 0) begin
        acc += hist_bins[i];
        if (!got50 && acc >= t50) begin
          res.median_bin = i[lhp_pkg::BIN_FIELD_W-1:0];
          got50 = 1'b1;
        end
        if (!got99 && acc >= t99) begin
          res.p99_bin = i[lhp_pkg::BIN_FIELD_W-1:0];
          got99 = 1'b1;
        end
        if (!got999 && acc >= t999) begin
          res.p999_bin = i[lhp_pkg::BIN_FIELD_W-1:0];
          got999 = 1'b1;
        end
        if (got50 && got99 && got999) begin
          break;
        end
      end
    end
    return res;
  endfunction

  task automatic push_req(lhp_pkg::req_type_t kind, logic [lhp_pkg::LAT_W-1:0] lat);
    lhp_pkg::in_req_t req;
    req.req_type = kind;
    req.latency_us = lat;
    pending_reqs.push_back(req);
    total_reqs++;
  endtask

  // Driver: a new request is presented only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= roll_idle();
      if (!in_valid || in_taken) begin
        if (pending_reqs.size() > 0 && !roll_idle()) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor, predictor and watchdog.
  always @(posedge clk) begin
    lhp_pkg::out_res_t want;
    logic              in_fire, out_fire;
    in_fire = rst_n && in_valid && !in_stall;
    out_fire = rst_n && out_valid && !out_stall;
    in_taken <= in_fire;
    if (in_fire) begin
      reqs_taken++;
      if (in_data.req_type == lhp_pkg::REQ_ADD) begin
        record_latency(in_data.latency_us);
      end else begin
        pct_expected.push_back(percentile_snapshot());
      end
    end
    if (out_fire) begin
      if (pct_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected result: has=%0d med=%0d p99=%0d p999=%0d",
                   out_data.has_samples, out_data.median_bin, out_data.p99_bin,
                   out_data.p999_bin);
        end
      end else begin
        want = pct_expected.pop_front();
        if (out_data.has_samples !== want.has_samples ||
            out_data.median_bin !== want.median_bin ||
            out_data.p99_bin !== want.p99_bin ||
            out_data.p999_bin !== want.p999_bin) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display({"mismatch: expected has=%0d med=%0d p99=%0d p999=%0d,",
                      " got has=%0d med=%0d p99=%0d p999=%0d"},
                     want.has_samples, want.median_bin, want.p99_bin, want.p999_bin,
                     out_data.has_samples, out_data.median_bin, out_data.p99_bin,
                     out_data.p999_bin);
          end
        end
      end
    end
    if (in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request or result moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n_queries;
    int pick;
    logic [lhp_pkg::LAT_W-1:0] lat;
    n_queries = 0;
    for (int i = 0; i < NUM_BINS; i++) begin
      hist_bins[i] = '0;
    end
    hist_total = '0;

    // Empty histogram, single samples, clamping of large latencies.
    push_req(lhp_pkg::REQ_QUERY, 24'h000000);
    push_req(lhp_pkg::REQ_ADD, 24'h000000);
    push_req(lhp_pkg::REQ_QUERY, 24'hFFFFFF);
    push_req(lhp_pkg::REQ_ADD, 24'hFFFFFF);
    push_req(lhp_pkg::REQ_QUERY, 24'h000000);
    push_req(lhp_pkg::REQ_ADD, 24'd4095);
    push_req(lhp_pkg::REQ_ADD, 24'd4096);
    push_req(lhp_pkg::REQ_ADD, 24'h800000);
    push_req(lhp_pkg::REQ_ADD, 24'h555555);
    push_req(lhp_pkg::REQ_ADD, 24'hAAAAAA);
    push_req(lhp_pkg::REQ_QUERY, 24'h555555);
    push_req(lhp_pkg::REQ_ADD, 24'h000AAA);
    push_req(lhp_pkg::REQ_ADD, 24'h000555);
    push_req(lhp_pkg::REQ_ADD, 24'h000001);
    push_req(lhp_pkg::REQ_ADD, 24'h000800);
    push_req(lhp_pkg::REQ_ADD, 24'h000001);
    push_req(lhp_pkg::REQ_QUERY, 24'hAAAAAA);
    for (int i = 0; i < 6; i++) begin
      push_req(lhp_pkg::REQ_ADD, 24'd7);
    end
    push_req(lhp_pkg::REQ_QUERY, 24'h000FFF);

    // Mostly adds spread over the bins, with clusters to give
    // distinct percentiles, and occasional queries.
    while (total_reqs < RANDOM_ITEMS + 25 || n_queries < MIN_QUERIES) begin
      if ($urandom_range(0, 99) < 4) begin
        push_req(lhp_pkg::REQ_QUERY, lhp_pkg::LAT_W'($urandom()));
        n_queries++;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          lat = lhp_pkg::LAT_W'($urandom_range(0, lhp_pkg::MAX_LATENCY_DEF));
        end else if (pick < 7) begin
          lat = lhp_pkg::LAT_W'($urandom_range(100, 140));
        end else if (pick == 7) begin
          lat = lhp_pkg::LAT_W'($urandom_range(0, 15));
        end else begin
          lat = lhp_pkg::LAT_W'($urandom());
        end
        push_req(lhp_pkg::REQ_ADD, lat);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (reqs_taken < total_reqs) begin
      @(posedge clk);
    end
    while (pct_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/lhp_pkg.sv
src/latency_histogram_percentiles.sv
src/lhp_checker.sv
tb/tb_latency_histogram_percentiles.sv
